// ----- src/rmtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracking controller package
// Shared types, register indexes and the micro-program of the sequencer.
// ----------------------------------------------------------------------------
package rmtc_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CFG_W  = 31;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned STEP_W = 5;

	typedef logic signed [DATA_W-1:0] fix_t;

	localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ORDER_MODE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_TIME_STEP      = 3'd1;
	localparam logic [IDX_W-1:0] REG_REF_GAIN_ONE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_REF_GAIN_TWO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_REF_GAIN_THREE = 3'd4;
	localparam logic [IDX_W-1:0] REG_ERR_GAIN_ONE   = 3'd5;
	localparam logic [IDX_W-1:0] REG_ERR_GAIN_TWO   = 3'd6;
	localparam logic [IDX_W-1:0] REG_ERR_GAIN_THREE = 3'd7;

	localparam logic [1:0] ORDER_SECOND = 2'd2;
	localparam logic [1:0] ORDER_RESET  = 2'd3;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

	typedef enum logic [4:0] {
		SRC_R,
		SRC_POS,
		SRC_RATE,
		SRC_ACCEL,
		SRC_VC,
		SRC_JERK,
		SRC_DES,
		SRC_MPOS,
		SRC_MRATE,
		SRC_MACC,
		SRC_DT,
		SRC_K1,
		SRC_K2,
		SRC_K3,
		SRC_KE1,
		SRC_KE2,
		SRC_KE3,
		SRC_ZERO
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_ACCEL,
		DST_RATE,
		DST_POS,
		DST_JERK,
		DST_VC
	} dst_t;

	typedef struct packed {
		alu_op_t op;
		src_t    a;
		src_t    b;
		dst_t    dst;
		logic    last;
	} uop_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} seq_state_t;

	function automatic uop_t make_uop(alu_op_t op, src_t a, src_t b, dst_t d, logic l);
		uop_t u;
		u.op   = op;
		u.a    = a;
		u.b    = b;
		u.dst  = d;
		u.last = l;
		return u;
	endfunction

	// One ALU operation per step. The ALU result of every step lands in the
	// scratch register R and, where named, in one state register as well.
	function automatic uop_t program_step(logic [STEP_W-1:0] step, logic second);
		uop_t u;
		u = make_uop(ALU_ADD, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1);
		if (second) begin
			case (step)
				5'd0:  u = make_uop(ALU_SUB, SRC_DES,   SRC_POS,   DST_NONE,  1'b0);
				5'd1:  u = make_uop(ALU_MUL, SRC_K1,    SRC_R,     DST_NONE,  1'b0);
				5'd2:  u = make_uop(ALU_SUB, SRC_R,     SRC_RATE,  DST_NONE,  1'b0);
				5'd3:  u = make_uop(ALU_MUL, SRC_K2,    SRC_R,     DST_NONE,  1'b0);
				5'd4:  u = make_uop(ALU_ADD, SRC_R,     SRC_ZERO,  DST_ACCEL, 1'b0);
				5'd5:  u = make_uop(ALU_MUL, SRC_DT,    SRC_ACCEL, DST_NONE,  1'b0);
				5'd6:  u = make_uop(ALU_ADD, SRC_RATE,  SRC_R,     DST_RATE,  1'b0);
				5'd7:  u = make_uop(ALU_MUL, SRC_DT,    SRC_RATE,  DST_NONE,  1'b0);
				5'd8:  u = make_uop(ALU_ADD, SRC_POS,   SRC_R,     DST_POS,   1'b0);
				5'd9:  u = make_uop(ALU_SUB, SRC_POS,   SRC_MPOS,  DST_NONE,  1'b0);
				5'd10: u = make_uop(ALU_MUL, SRC_KE1,   SRC_R,     DST_VC,    1'b0);
				5'd11: u = make_uop(ALU_SUB, SRC_RATE,  SRC_MRATE, DST_NONE,  1'b0);
				5'd12: u = make_uop(ALU_MUL, SRC_KE2,   SRC_R,     DST_NONE,  1'b0);
				5'd13: u = make_uop(ALU_ADD, SRC_VC,    SRC_R,     DST_VC,    1'b0);
				5'd14: u = make_uop(ALU_ADD, SRC_VC,    SRC_ACCEL, DST_VC,    1'b1);
				default: u = make_uop(ALU_ADD, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1);
			endcase
		end else begin
			case (step)
				5'd0:  u = make_uop(ALU_SUB, SRC_DES,   SRC_POS,   DST_NONE,  1'b0);
				5'd1:  u = make_uop(ALU_MUL, SRC_K1,    SRC_R,     DST_NONE,  1'b0);
				5'd2:  u = make_uop(ALU_SUB, SRC_R,     SRC_RATE,  DST_NONE,  1'b0);
				5'd3:  u = make_uop(ALU_MUL, SRC_K2,    SRC_R,     DST_NONE,  1'b0);
				5'd4:  u = make_uop(ALU_SUB, SRC_R,     SRC_ACCEL, DST_NONE,  1'b0);
				5'd5:  u = make_uop(ALU_MUL, SRC_K3,    SRC_R,     DST_JERK,  1'b0);
				5'd6:  u = make_uop(ALU_MUL, SRC_DT,    SRC_R,     DST_NONE,  1'b0);
				5'd7:  u = make_uop(ALU_ADD, SRC_ACCEL, SRC_R,     DST_ACCEL, 1'b0);
				5'd8:  u = make_uop(ALU_MUL, SRC_DT,    SRC_ACCEL, DST_NONE,  1'b0);
				5'd9:  u = make_uop(ALU_ADD, SRC_RATE,  SRC_R,     DST_RATE,  1'b0);
				5'd10: u = make_uop(ALU_MUL, SRC_DT,    SRC_RATE,  DST_NONE,  1'b0);
				5'd11: u = make_uop(ALU_ADD, SRC_POS,   SRC_R,     DST_POS,   1'b0);
				5'd12: u = make_uop(ALU_SUB, SRC_POS,   SRC_MPOS,  DST_NONE,  1'b0);
				5'd13: u = make_uop(ALU_MUL, SRC_KE1,   SRC_R,     DST_VC,    1'b0);
				5'd14: u = make_uop(ALU_SUB, SRC_RATE,  SRC_MRATE, DST_NONE,  1'b0);
				5'd15: u = make_uop(ALU_MUL, SRC_KE2,   SRC_R,     DST_NONE,  1'b0);
				5'd16: u = make_uop(ALU_ADD, SRC_VC,    SRC_R,     DST_VC,    1'b0);
				5'd17: u = make_uop(ALU_SUB, SRC_ACCEL, SRC_MACC,  DST_NONE,  1'b0);
				5'd18: u = make_uop(ALU_MUL, SRC_KE3,   SRC_R,     DST_NONE,  1'b0);
				5'd19: u = make_uop(ALU_ADD, SRC_VC,    SRC_R,     DST_VC,    1'b0);
				5'd20: u = make_uop(ALU_ADD, SRC_VC,    SRC_JERK,  DST_VC,    1'b1);
				default: u = make_uop(ALU_ADD, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1);
			endcase
		end
		return u;
	endfunction

	localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

endpackage
`default_nettype wire

// ----- src/rmtc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared saturating ALU
// Q16.16 add, subtract and multiply, each saturated to the 32-bit range.
// ----------------------------------------------------------------------------
module rmtc_alu import rmtc_pkg::*; (
	input  alu_op_t op,
	input  fix_t    a,
	input  fix_t    b,
	output fix_t    res
);

	logic signed [2*DATA_W-1:0] prod;
	logic signed [DATA_W:0]     ax;
	logic signed [DATA_W:0]     bx;
	logic signed [DATA_W:0]     sum;
	fix_t                       sum_sat;
	fix_t                       prod_sat;

	always_comb begin
		ax = {a[DATA_W-1], a};
		bx = {b[DATA_W-1], b};
		if (op == ALU_SUB) begin
			sum = ax - bx;
		end else begin
			sum = ax + bx;
		end
		if (sum[DATA_W] != sum[DATA_W-1]) begin
			sum_sat = sum[DATA_W] ? FIX_MIN : FIX_MAX;
		end else begin
			sum_sat = sum[DATA_W-1:0];
		end
	end

	// The arithmetic shift by 16 floors; the product fits when the bits above
	// the kept field are all equal to its sign.
	always_comb begin
		prod = 64'(a) * 64'(b);
		if ((&prod[63:47]) || !(|prod[63:47])) begin
			prod_sat = prod[47:16];
		end else begin
			prod_sat = prod[63] ? FIX_MIN : FIX_MAX;
		end
	end

	always_comb begin
		case (op)
			ALU_MUL: res = prod_sat;
			ALU_ADD,
			ALU_SUB: res = sum_sat;
			default: res = sum_sat;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/rmtc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Micro-program sequencer
// Steps the shared ALU through one control tick and runs the handshakes.
// ----------------------------------------------------------------------------
module rmtc_seq import rmtc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_stall,
	input  logic second,
	output logic in_stall,
	output logic out_valid,
	output logic start,
	output logic exec,
	output uop_t uop
);

	seq_state_t          state_q;
	seq_state_t          state_next;
	logic [STEP_W-1:0]   step_q;

	assign uop = program_step(step_q, second);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_RUN;
			end
			ST_RUN: begin
				if (uop.last) state_next = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_stall) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_HOLD);
		exec      = (state_q == ST_RUN);
		start     = (state_q == ST_IDLE) && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (start) begin
				step_q <= '0;
			end else if (exec && !uop.last) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> step_q <= LAST_STEP)
		else $error("sequencer step ran past the end of the program");

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> exec && step_q == '0)
		else $error("accepted item did not start at the first step");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(exec && uop.last))
		else $error("result shown without finishing the program");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid && !in_stall)
		else $error("block did not return to idle after delivery");

endmodule
`default_nettype wire

// ----- src/reference_model_tracking_controller_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tracking controller
// One axis, Q16.16: cascaded reference filter and error controller.
// ----------------------------------------------------------------------------
// One item is one control tick. Once it is taken, a single saturating ALU
// (one 32x32 multiply or one add/subtract per cycle) runs the tick's
// micro-program: 21 steps in third-order mode, 15 in second-order mode.
// The result then shows until taken. The input is stalled from acceptance
// until the result is taken.
module reference_model_tracking_controller_unit import rmtc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_write_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,

	input  logic              in_valid,
	output logic              in_stall,
	input  fix_t              desired_value,
	input  fix_t              meas_pos,
	input  fix_t              meas_rate,
	input  fix_t              meas_accel,

	output logic              out_valid,
	input  logic              out_stall,
	output fix_t              virtual_control,
	output fix_t              ref_pos_out,
	output fix_t              ref_rate_out,
	output fix_t              ref_accel_out,
	output fix_t              ref_jerk
);

	logic [1:0]       order_q;
	logic [16:0]      dt_q;
	logic [CFG_W-1:0] k1_q;
	logic [CFG_W-1:0] k2_q;
	logic [CFG_W-1:0] k3_q;
	logic [CFG_W-1:0] ke1_q;
	logic [CFG_W-1:0] ke2_q;
	logic [CFG_W-1:0] ke3_q;

	fix_t des_q;
	fix_t mpos_q;
	fix_t mrate_q;
	fix_t macc_q;

	fix_t pos_q;
	fix_t rate_q;
	fix_t accel_q;
	fix_t jerk_q;
	fix_t vc_q;
	fix_t r_q;

	logic second;
	logic start;
	logic exec;
	uop_t uop;
	fix_t opa;
	fix_t opb;
	fix_t res;

	assign second = (order_q == ORDER_SECOND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
			dt_q    <= '0;
			k1_q    <= '0;
			k2_q    <= '0;
			k3_q    <= '0;
			ke1_q   <= '0;
			ke2_q   <= '0;
			ke3_q   <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_ORDER_MODE:     order_q <= cfg_data[1:0];
				REG_TIME_STEP:      dt_q    <= cfg_data[16:0];
				REG_REF_GAIN_ONE:   k1_q    <= cfg_data;
				REG_REF_GAIN_TWO:   k2_q    <= cfg_data;
				REG_REF_GAIN_THREE: k3_q    <= cfg_data;
				REG_ERR_GAIN_ONE:   ke1_q   <= cfg_data;
				REG_ERR_GAIN_TWO:   ke2_q   <= cfg_data;
				REG_ERR_GAIN_THREE: ke3_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	rmtc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.second    (second),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.start     (start),
		.exec      (exec),
		.uop       (uop)
	);

	function automatic fix_t pick(src_t s, fix_t r, fix_t pos, fix_t rate, fix_t accel,
		fix_t vc, fix_t jerk, fix_t des, fix_t mpos, fix_t mrate, fix_t macc,
		logic [16:0] dt, logic [CFG_W-1:0] k1, logic [CFG_W-1:0] k2,
		logic [CFG_W-1:0] k3, logic [CFG_W-1:0] ke1, logic [CFG_W-1:0] ke2,
		logic [CFG_W-1:0] ke3);
		fix_t v;
		case (s)
			SRC_R:     v = r;
			SRC_POS:   v = pos;
			SRC_RATE:  v = rate;
			SRC_ACCEL: v = accel;
			SRC_VC:    v = vc;
			SRC_JERK:  v = jerk;
			SRC_DES:   v = des;
			SRC_MPOS:  v = mpos;
			SRC_MRATE: v = mrate;
			SRC_MACC:  v = macc;
			SRC_DT:    v = {15'd0, dt};
			SRC_K1:    v = {1'b0, k1};
			SRC_K2:    v = {1'b0, k2};
			SRC_K3:    v = {1'b0, k3};
			SRC_KE1:   v = {1'b0, ke1};
			SRC_KE2:   v = {1'b0, ke2};
			SRC_KE3:   v = {1'b0, ke3};
			SRC_ZERO:  v = '0;
			default:   v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(uop.a, r_q, pos_q, rate_q, accel_q, vc_q, jerk_q, des_q, mpos_q,
			mrate_q, macc_q, dt_q, k1_q, k2_q, k3_q, ke1_q, ke2_q, ke3_q);
		opb = pick(uop.b, r_q, pos_q, rate_q, accel_q, vc_q, jerk_q, des_q, mpos_q,
			mrate_q, macc_q, dt_q, k1_q, k2_q, k3_q, ke1_q, ke2_q, ke3_q);
	end

	rmtc_alu u_alu (
		.op  (uop.op),
		.a   (opa),
		.b   (opb),
		.res (res)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			des_q   <= desired_value;
			mpos_q  <= meas_pos;
			mrate_q <= meas_rate;
			macc_q  <= meas_accel;
		end
		if (exec) begin
			r_q <= res;
		end
	end

	// Reference state lives across ticks; the jerk is cleared at every new
	// item so that second-order ticks report zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			rate_q  <= '0;
			accel_q <= '0;
			jerk_q  <= '0;
			vc_q    <= '0;
		end else if (start) begin
			jerk_q <= '0;
		end else if (exec) begin
			case (uop.dst)
				DST_ACCEL: accel_q <= res;
				DST_RATE:  rate_q  <= res;
				DST_POS:   pos_q   <= res;
				DST_JERK:  jerk_q  <= res;
				DST_VC:    vc_q    <= res;
				DST_NONE:  ;
				default:   ;
			endcase
		end
	end

	assign virtual_control = vc_q;
	assign ref_pos_out     = pos_q;
	assign ref_rate_out    = rate_q;
	assign ref_accel_out   = accel_q;
	assign ref_jerk        = jerk_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && second) |-> jerk_q == '0)
		else $error("nonzero jerk reported in second-order mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		(exec && uop.dst == DST_JERK) |-> !second)
		else $error("jerk written in second-order mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(virtual_control)
			&& $stable(ref_pos_out) && $stable(ref_rate_out)
			&& $stable(ref_accel_out) && $stable(ref_jerk))
		else $error("stalled result changed or was dropped");

endmodule
`default_nettype wire

// ----- tb/sv/reference_model_tracking_controller_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference model tracking controller testbench
// Sends control ticks through the valid/stall handshakes while both sides
// idle at random. A Q16.16 predictor of the reference cascade and the error
// controller gives every result, and each field is compared on arrival.
// ----------------------------------------------------------------------------
module reference_model_tracking_controller_unit_tb import rmtc_pkg::*; ();

	// Order codes that have no name of their own; both select third order.
	localparam logic [1:0] ORDER_CODE_ZERO = 2'd0;
	localparam logic [1:0] ORDER_CODE_ONE  = 2'd1;

	localparam logic [CFG_W-1:0] ONE_Q16 = 31'h0001_0000;

	typedef struct {
		fix_t vc;
		fix_t pos;
		fix_t rate;
		fix_t accel;
		fix_t jerk;
	} tick_result_t;

	class tick_scoreboard;
		logic [CFG_W-1:0] cfg [8];
		fix_t ref_pos;
		fix_t ref_rate;
		fix_t ref_accel;
		tick_result_t tick_results [$];
		int errors;

		function new();
			foreach (cfg[i]) cfg[i] = '0;
			cfg[REG_ORDER_MODE] = CFG_W'(ORDER_RESET);
			ref_pos = '0;
			ref_rate = '0;
			ref_accel = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ORDER_MODE: cfg[idx] = CFG_W'(data[1:0]);
				REG_TIME_STEP:  cfg[idx] = CFG_W'(data[16:0]);
				default:        cfg[idx] = data;
			endcase
		endfunction

		function int pending();
			return tick_results.size();
		endfunction

		function fix_t sat(longint v);
			if (v > longint'(FIX_MAX))
				return FIX_MAX;
			if (v < longint'(FIX_MIN))
				return FIX_MIN;
			return fix_t'(v);
		endfunction

		function fix_t fx_add(fix_t a, fix_t b);
			return sat(longint'(a) + longint'(b));
		endfunction

		function fix_t fx_sub(fix_t a, fix_t b);
			return sat(longint'(a) - longint'(b));
		endfunction

		// The arithmetic shift of the exact product rounds toward minus infinity.
		function fix_t fx_mul(fix_t a, fix_t b);
			longint p;
			p = longint'(a) * longint'(b);
			return sat(p >>> 16);
		endfunction

		function void advance_reference(fix_t des, fix_t mpos, fix_t mrate, fix_t macc);
			fix_t dt, k1, k2, k3, ke1, ke2, ke3;
			fix_t ex, ev, jerk, vc;
			logic second;
			tick_result_t r;
			dt = fix_t'(cfg[REG_TIME_STEP]);
			k1 = fix_t'(cfg[REG_REF_GAIN_ONE]);
			k2 = fix_t'(cfg[REG_REF_GAIN_TWO]);
			k3 = fix_t'(cfg[REG_REF_GAIN_THREE]);
			ke1 = fix_t'(cfg[REG_ERR_GAIN_ONE]);
			ke2 = fix_t'(cfg[REG_ERR_GAIN_TWO]);
			ke3 = fix_t'(cfg[REG_ERR_GAIN_THREE]);
			second = (cfg[REG_ORDER_MODE][1:0] == ORDER_SECOND);
			jerk = '0;
			ex = fx_mul(k1, fx_sub(des, ref_pos));
			ev = fx_mul(k2, fx_sub(ex, ref_rate));
			if (second) begin
				ref_accel = ev;
			end else begin
				jerk = fx_mul(k3, fx_sub(ev, ref_accel));
				ref_accel = fx_add(ref_accel, fx_mul(dt, jerk));
			end
			ref_rate = fx_add(ref_rate, fx_mul(dt, ref_accel));
			ref_pos = fx_add(ref_pos, fx_mul(dt, ref_rate));
			vc = fx_mul(ke1, fx_sub(ref_pos, mpos));
			vc = fx_add(vc, fx_mul(ke2, fx_sub(ref_rate, mrate)));
			if (second) begin
				vc = fx_add(vc, ref_accel);
			end else begin
				vc = fx_add(vc, fx_mul(ke3, fx_sub(ref_accel, macc)));
				vc = fx_add(vc, jerk);
			end
			r.vc = vc;
			r.pos = ref_pos;
			r.rate = ref_rate;
			r.accel = ref_accel;
			r.jerk = jerk;
			tick_results.push_back(r);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, fix_t got, fix_t want);
			if (got !== want)
				report($sformatf("%s is %0d, predicted %0d", name, got, want));
		endtask

		task check_result(tick_result_t got);
			tick_result_t want;
			if (tick_results.size() == 0) begin
				report("result arrived with no tick outstanding");
			end else begin
				want = tick_results.pop_front();
				compare_field("virtual_control", got.vc, want.vc);
				compare_field("ref_pos_out", got.pos, want.pos);
				compare_field("ref_rate_out", got.rate, want.rate);
				compare_field("ref_accel_out", got.accel, want.accel);
				compare_field("ref_jerk", got.jerk, want.jerk);
			end
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	fix_t             desired_value = '0;
	fix_t             meas_pos = '0;
	fix_t             meas_rate = '0;
	fix_t             meas_accel = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	fix_t             virtual_control;
	fix_t             ref_pos_out;
	fix_t             ref_rate_out;
	fix_t             ref_accel_out;
	fix_t             ref_jerk;

	tick_scoreboard sb;
	int send_idle = 33;
	int recv_idle = 55;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	reference_model_tracking_controller_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.desired_value(desired_value),
		.meas_pos(meas_pos),
		.meas_rate(meas_rate),
		.meas_accel(meas_accel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.virtual_control(virtual_control),
		.ref_pos_out(ref_pos_out),
		.ref_rate_out(ref_rate_out),
		.ref_accel_out(ref_accel_out),
		.ref_jerk(ref_jerk)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// A hold-off request makes the receiver stall for a long, counted stretch.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		tick_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.vc = virtual_control;
			got.pos = ref_pos_out;
			got.rate = ref_rate_out;
			got.accel = ref_accel_out;
			got.jerk = ref_jerk;
			sb.check_result(got);
		end
	end

	// All driving tasks start and end at a falling edge.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic send_item(fix_t des, fix_t mpos, fix_t mrate, fix_t macc);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		desired_value <= des;
		meas_pos <= mpos;
		meas_rate <= mrate;
		meas_accel <= macc;
		do @(posedge clk); while (in_stall);
		sb.advance_reference(des, mpos, mrate, macc);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic fix_t random_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			case ($urandom_range(3))
				0: return FIX_MAX;
				1: return FIX_MIN;
				2: return '0;
				default: return -1;
			endcase
		end
		if (pick < 30)
			return fix_t'($urandom());
		// Within about 128.0 of zero, where the reference rarely saturates.
		return fix_t'($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
	endfunction

	function automatic logic [CFG_W-1:0] random_gain();
		case ($urandom_range(7))
			0: return '0;
			1: return {CFG_W{1'b1}};
			2: return CFG_W'($urandom());
			default: return CFG_W'($urandom_range(32'h0008_0000));
		endcase
	endfunction

	task automatic random_config();
		logic [CFG_W-1:0] data;
		data = CFG_W'($urandom());
		if ($urandom_range(1))
			data[1:0] = ORDER_SECOND;
		write_reg(REG_ORDER_MODE, data);
		case ($urandom_range(3))
			0: data = '0;
			1: data = ONE_Q16;
			2: data = CFG_W'($urandom());
			default: data = CFG_W'($urandom_range(3277, 1));
		endcase
		write_reg(REG_TIME_STEP, data);
		for (int i = REG_REF_GAIN_ONE; i <= REG_ERR_GAIN_THREE; i++)
			write_reg(IDX_W'(i), random_gain());
	endtask

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: third order with every gain at zero.
		send_item('0, '0, '0, '0);
		send_item(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
		wait_for_results();

		// Third order with moderate gains and a 10 ms step.
		write_reg(REG_ORDER_MODE, CFG_W'(ORDER_RESET));
		write_reg(REG_TIME_STEP, 31'd655);
		write_reg(REG_REF_GAIN_ONE, 31'h0002_0000);
		write_reg(REG_REF_GAIN_TWO, 31'h0004_0000);
		write_reg(REG_REF_GAIN_THREE, 31'h0008_0000);
		write_reg(REG_ERR_GAIN_ONE, ONE_Q16);
		write_reg(REG_ERR_GAIN_TWO, 31'h0002_0000);
		write_reg(REG_ERR_GAIN_THREE, 31'h0000_8000);
		repeat (3) send_item(32'sh0001_0000, '0, '0, '0);
		send_item(FIX_MAX, FIX_MIN, FIX_MIN, FIX_MAX);
		send_item(FIX_MIN, FIX_MAX, FIX_MAX, FIX_MIN);
		send_item(-1, -1, -1, -1);
		wait_for_results();

		// Largest gains and a step of one second; bits above the step width drop.
		write_reg(REG_TIME_STEP, 31'h7FFF_0000);
		for (int i = REG_REF_GAIN_ONE; i <= REG_ERR_GAIN_THREE; i++)
			write_reg(IDX_W'(i), {CFG_W{1'b1}});
		send_item(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
		send_item(FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX);
		send_item('0, '0, '0, '0);
		wait_for_results();

		// Second order with the third-order gains left at their largest.
		write_reg(REG_ORDER_MODE, 31'h7FFF_FFFE);
		write_reg(REG_TIME_STEP, 31'd655);
		write_reg(REG_REF_GAIN_ONE, 31'h0002_0000);
		write_reg(REG_REF_GAIN_TWO, 31'h0004_0000);
		write_reg(REG_ERR_GAIN_ONE, ONE_Q16);
		write_reg(REG_ERR_GAIN_TWO, ONE_Q16);
		send_item(32'sh0001_0000, '0, '0, FIX_MAX);
		send_item(32'sh0001_0000, '0, '0, FIX_MIN);
		send_item(FIX_MAX, FIX_MIN, FIX_MAX, '0);
		send_item(FIX_MIN, FIX_MAX, FIX_MIN, -1);
		wait_for_results();

		// The two order codes without meaning select third order; a zero step too.
		write_reg(REG_ORDER_MODE, CFG_W'(ORDER_CODE_ZERO));
		send_item(32'sh0003_0000, 32'sh0001_0000, '0, '0);
		send_item(32'sh0003_0000, 32'sh0001_0000, '0, '0);
		wait_for_results();
		write_reg(REG_ORDER_MODE, CFG_W'(ORDER_CODE_ONE));
		write_reg(REG_TIME_STEP, '0);
		send_item(32'sh0003_0000, '0, 32'sh0001_0000, '0);
		send_item(-32'sh0003_0000, '0, '0, 32'sh0001_0000);
		wait_for_results();

		for (int phase = 0; phase < 8; phase++) begin
			if (phase < 3) begin
				send_idle = 33;
				recv_idle = 55;
			end else if (phase < 6) begin
				send_idle = 55;
				recv_idle = 33;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_config();
			for (int n = 0; n < 100; n++) begin
				// The sender keeps offering items through the hold-off.
				if ((phase == 1 || phase == 6) && n == 50)
					hold_req++;
				if ($urandom_range(49) == 0)
					wait_for_results();
				send_item(random_value(), random_value(), random_value(), random_value());
			end
			wait_for_results();
		end

		in_valid <= 1'b0;
		for (int c = 0; c < 20000 && sb.pending() != 0; c++)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
